@@ src/ctst_pkg.sv @@
// Shared types, token codes and lookup functions for the C-subset tokenizer.
// No dependencies; used by ctst_scan, ctst_resq and c_subset_tokenizer_core.
package ctst_pkg;

  localparam int unsigned MaxTextDef  = 512;
  localparam int unsigned PosLimitDef = 2097152;
  localparam int unsigned PosOutW     = 22;
  localparam int unsigned KwCount     = 12;

  typedef enum logic [1:0] {
    RES_TOKEN = 2'd0,
    RES_TEXT  = 2'd1,
    RES_ERROR = 2'd2
  } res_type_e;

  typedef enum logic [1:0] {
    ERR_DIRECTIVE = 2'd0,
    ERR_CHAR      = 2'd1,
    ERR_BAR       = 2'd2,
    ERR_BYTE      = 2'd3
  } err_code_e;

  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_DEFINE = 6'd13;
  localparam logic [5:0] K_IDENT  = 6'd14;
  localparam logic [5:0] K_INT    = 6'd15;
  localparam logic [5:0] K_CHAR   = 6'd16;
  localparam logic [5:0] K_STR    = 6'd17;
  localparam logic [5:0] K_LPAREN = 6'd18;
  localparam logic [5:0] K_RPAREN = 6'd19;
  localparam logic [5:0] K_LBRACE = 6'd20;
  localparam logic [5:0] K_RBRACE = 6'd21;
  localparam logic [5:0] K_LBRACK = 6'd22;
  localparam logic [5:0] K_RBRACK = 6'd23;
  localparam logic [5:0] K_SEMI   = 6'd24;
  localparam logic [5:0] K_COMMA  = 6'd25;
  localparam logic [5:0] K_DOT    = 6'd26;
  localparam logic [5:0] K_ARROW  = 6'd27;
  localparam logic [5:0] K_PLUS   = 6'd28;
  localparam logic [5:0] K_MINUS  = 6'd29;
  localparam logic [5:0] K_STAR   = 6'd30;
  localparam logic [5:0] K_SLASH  = 6'd31;
  localparam logic [5:0] K_PCT    = 6'd32;
  localparam logic [5:0] K_AMP    = 6'd33;
  localparam logic [5:0] K_BANG   = 6'd34;
  localparam logic [5:0] K_OROR   = 6'd35;
  localparam logic [5:0] K_ANDAND = 6'd36;
  localparam logic [5:0] K_ASSIGN = 6'd37;
  localparam logic [5:0] K_ADDEQ  = 6'd38;
  localparam logic [5:0] K_SUBEQ  = 6'd39;
  localparam logic [5:0] K_EQ     = 6'd40;
  localparam logic [5:0] K_NE     = 6'd41;
  localparam logic [5:0] K_LT     = 6'd42;
  localparam logic [5:0] K_GT     = 6'd43;
  localparam logic [5:0] K_LE     = 6'd44;
  localparam logic [5:0] K_GE     = 6'd45;
  localparam logic [5:0] K_INC    = 6'd46;
  localparam logic [5:0] K_DEC    = 6'd47;

  typedef enum logic [16:0] {
    M_IDLE   = 17'h00001,
    M_OP     = 17'h00002,
    M_LCMT   = 17'h00004,
    M_BLK    = 17'h00008,
    M_BSTAR  = 17'h00010,
    M_HGAP   = 17'h00020,
    M_HWORD  = 17'h00040,
    M_IDENT  = 17'h00080,
    M_ZERO   = 17'h00100,
    M_DECNUM = 17'h00200,
    M_HEX    = 17'h00400,
    M_COPEN  = 17'h00800,
    M_CESC   = 17'h01000,
    M_CCLOSE = 17'h02000,
    M_STR    = 17'h04000,
    M_SESC   = 17'h08000,
    M_SCAP   = 17'h10000
  } mode_e;

  typedef struct packed {
    res_type_e   rtype;
    logic [5:0]  kind;
    logic [31:0] value;
    logic [21:0] line;
    logic [21:0] col;
    logic [7:0]  tb;
    err_code_e   err;
    logic        last;
  } res_t;

  // Results of one accepted beat, handed from the scanner to the queue.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    case (i)
      4'd0: kw_len = 4'd3;  4'd1: kw_len = 4'd4;  4'd2: kw_len = 4'd4;
      4'd3: kw_len = 4'd6;  4'd4: kw_len = 4'd2;  4'd5: kw_len = 4'd4;
      4'd6: kw_len = 4'd5;  4'd7: kw_len = 4'd3;  4'd8: kw_len = 4'd5;
      4'd9: kw_len = 4'd8;  4'd10: kw_len = 4'd6; 4'd11: kw_len = 4'd6;
      default: kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [63:0] kw_word(input logic [3:0] i);
    case (i)
      4'd0: kw_word = 64'("int");     4'd1: kw_word = 64'("char");
      4'd2: kw_word = 64'("void");    4'd3: kw_word = 64'("return");
      4'd4: kw_word = 64'("if");      4'd5: kw_word = 64'("else");
      4'd6: kw_word = 64'("while");   4'd7: kw_word = 64'("for");
      4'd8: kw_word = 64'("break");   4'd9: kw_word = 64'("continue");
      4'd10: kw_word = 64'("struct"); 4'd11: kw_word = 64'("sizeof");
      default: kw_word = 64'd0;
    endcase
  endfunction

  // Letter p (from the left) of keyword i; valid for p below its length.
  function automatic logic [7:0] kw_char(input logic [3:0] i, input logic [2:0] p);
    logic [63:0] w;
    logic [3:0]  sh;
    w  = kw_word(i);
    sh = kw_len(i) - 4'd1 - {1'b0, p};
    kw_char = w[{sh[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] dir_char(input logic [2:0] p);
    case (p)
      3'd0: dir_char = "d"; 3'd1: dir_char = "e"; 3'd2: dir_char = "f";
      3'd3: dir_char = "i"; 3'd4: dir_char = "n"; 3'd5: dir_char = "e";
      default: dir_char = 8'd0;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = b >= "0" && b <= "9";
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (is_digit(b)) hex_value = 5'(b - "0");
    else if (b >= "a" && b <= "f") hex_value = 5'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hex_value = 5'(b - "A" + 8'd10);
    else hex_value = 5'd16;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    case (b)
      "n": unescape = 8'd10;
      "t": unescape = 8'd9;
      "0": unescape = 8'd0;
      default: unescape = b;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    case (p)
      "+": single_kind = K_PLUS;
      "-": single_kind = K_MINUS;
      "&": single_kind = K_AMP;
      "!": single_kind = K_BANG;
      "=": single_kind = K_ASSIGN;
      "<": single_kind = K_LT;
      ">": single_kind = K_GT;
      default: single_kind = K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
    pair_kind = K_END;
    case (p)
      "+": if (b == "+") pair_kind = K_INC; else if (b == "=") pair_kind = K_ADDEQ;
      "-": if (b == "-") pair_kind = K_DEC; else if (b == "=") pair_kind = K_SUBEQ;
           else if (b == ">") pair_kind = K_ARROW;
      "&": if (b == "&") pair_kind = K_ANDAND;
      "|": if (b == "|") pair_kind = K_OROR;
      "!": if (b == "=") pair_kind = K_NE;
      "=": if (b == "=") pair_kind = K_EQ;
      "<": if (b == "=") pair_kind = K_LE;
      ">": if (b == "=") pair_kind = K_GE;
      default: pair_kind = K_END;
    endcase
  endfunction

endpackage

@@ src/ctst_scan.sv @@
// Front end of the tokenizer: per-byte scanner state machine.
// Depends on ctst_pkg; emits up to two results per accepted beat.
module ctst_scan #(
  parameter int unsigned MaxText  = ctst_pkg::MaxTextDef,
  parameter int unsigned PosLimit = ctst_pkg::PosLimitDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output ctst_pkg::push_t  push_o
);

  localparam int unsigned TLW = $clog2(MaxText);
  localparam int unsigned PW  = $clog2(PosLimit + 1);
  localparam logic [TLW-1:0] TextCap = TLW'(MaxText - 1);
  localparam logic [PW-1:0]  PosMax  = PW'(PosLimit);

  ctst_pkg::mode_e      mode_q, mode_d;
  logic [7:0]           pend_q, pend_d;
  logic [31:0]          acc_q, acc_d;
  logic [TLW-1:0]       tlen_q, tlen_d;
  logic [11:0]          kc_q, kc_d;
  logic [2:0]           dm_q, dm_d;
  logic [PW-1:0]        ln_q, ln_d, col_q, col_d, tsl_q, tsl_d, tsc_q, tsc_d;
  logic                 err_q, err_d;
  ctst_pkg::err_code_e  ekind_q, ekind_d;

  function automatic ctst_pkg::res_t mk(input ctst_pkg::res_type_e t, input logic [5:0] k,
                                        input logic [31:0] v, input logic [PW-1:0] l,
                                        input logic [PW-1:0] c, input logic [7:0] tb,
                                        input ctst_pkg::err_code_e e);
    ctst_pkg::res_t r;
    r.rtype = t; r.kind = k; r.value = v;
    r.line = ctst_pkg::PosOutW'(l); r.col = ctst_pkg::PosOutW'(c);
    r.tb = tb; r.err = e; r.last = 1'b0;
    mk = r;
  endfunction

  always_comb begin
    ctst_pkg::res_t rr [2];
    logic [1:0] n;
    logic       restart, do_ident, is_ws;
    logic [4:0] hv;
    logic [5:0] pk;
    logic [7:0] b, sv;
    mode_d = mode_q; pend_d = pend_q; acc_d = acc_q; tlen_d = tlen_q; kc_d = kc_q;
    dm_d = dm_q; ln_d = ln_q; col_d = col_q; tsl_d = tsl_q; tsc_d = tsc_q;
    err_d = err_q; ekind_d = ekind_q;
    rr[0] = '0; rr[1] = '0; n = 2'd0;
    restart = 1'b0; do_ident = 1'b0;
    b = byte_i;
    is_ws = b == " " || b == "\t" || b == "\n" || b == "\r";
    hv = ctst_pkg::hex_value(b);
    pk = ctst_pkg::pair_kind(pend_q, b);
    sv = 8'd0;
    if (err_q) begin
      rr[0] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0, ekind_q);
      n = 2'd1;
    end else if (end_i) begin
      // Flush whatever token is open, then give the end token if that raised no error.
      case (mode_q)
        ctst_pkg::M_OP: begin
          if (pend_q == "|") begin
            err_d = 1'b1; ekind_d = ctst_pkg::ERR_BAR;
            rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_BAR);
          end else begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::single_kind(pend_q), 32'd0,
                          tsl_q, tsc_q, 8'd0, ctst_pkg::ERR_DIRECTIVE);
          end
          n = n + 2'd1;
        end
        ctst_pkg::M_HGAP, ctst_pkg::M_HWORD: begin
          if (dm_q == 3'd6) begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_DEFINE, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
          end else begin
            err_d = 1'b1; ekind_d = ctst_pkg::ERR_DIRECTIVE;
            rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
          end
          n = n + 2'd1;
        end
        ctst_pkg::M_IDENT: begin
          pk = ctst_pkg::K_IDENT;
          for (int i = 0; i < ctst_pkg::KwCount; i++)
            if (kc_q[i] && TLW'(ctst_pkg::kw_len(4'(i))) == tlen_q) pk = 6'(i + 1);
          rr[n[0]] = mk(ctst_pkg::RES_TOKEN, pk, 32'd0, tsl_q, tsc_q, 8'd0,
                        ctst_pkg::ERR_DIRECTIVE);
          n = n + 2'd1;
        end
        ctst_pkg::M_ZERO, ctst_pkg::M_DECNUM, ctst_pkg::M_HEX: begin
          rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_INT, acc_q, tsl_q, tsc_q, 8'd0,
                        ctst_pkg::ERR_DIRECTIVE);
          n = n + 2'd1;
        end
        ctst_pkg::M_COPEN, ctst_pkg::M_CESC, ctst_pkg::M_CCLOSE: begin
          err_d = 1'b1; ekind_d = ctst_pkg::ERR_CHAR;
          rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                        ctst_pkg::ERR_CHAR);
          n = n + 2'd1;
        end
        ctst_pkg::M_STR, ctst_pkg::M_SESC: begin
          rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_STR, 32'(tlen_q), tsl_q, tsc_q, 8'd0,
                        ctst_pkg::ERR_DIRECTIVE);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_d = ctst_pkg::M_IDLE;
      if (!err_d) begin
        rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_END, 32'd0, ln_q, col_q, 8'd0,
                      ctst_pkg::ERR_DIRECTIVE);
        n = n + 2'd1;
      end
    end else begin
      // Feed the byte to the open token; restart means the byte begins a new one.
      case (mode_q)
        ctst_pkg::M_OP: begin
          if (pend_q == "/") begin
            if (b == "/") mode_d = ctst_pkg::M_LCMT;
            else if (b == "*") mode_d = ctst_pkg::M_BLK;
            else begin
              rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_SLASH, 32'd0, tsl_q, tsc_q,
                            8'd0, ctst_pkg::ERR_DIRECTIVE);
              n = n + 2'd1; restart = 1'b1;
            end
          end else if (pk != ctst_pkg::K_END) begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, pk, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; mode_d = ctst_pkg::M_IDLE;
          end else if (pend_q == "|") begin
            err_d = 1'b1; ekind_d = ctst_pkg::ERR_BAR; mode_d = ctst_pkg::M_IDLE;
            rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_BAR);
            n = n + 2'd1;
          end else begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::single_kind(pend_q), 32'd0,
                          tsl_q, tsc_q, 8'd0, ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; restart = 1'b1;
          end
        end
        ctst_pkg::M_LCMT: if (b == "\n") mode_d = ctst_pkg::M_IDLE;
        ctst_pkg::M_BLK: if (b == "*") mode_d = ctst_pkg::M_BSTAR;
        ctst_pkg::M_BSTAR: begin
          if (b == "/") mode_d = ctst_pkg::M_IDLE;
          else if (b != "*") mode_d = ctst_pkg::M_BLK;
        end
        ctst_pkg::M_HGAP, ctst_pkg::M_HWORD: begin
          if (mode_q == ctst_pkg::M_HGAP && (b == " " || b == "\t")) begin
            mode_d = mode_q;
          end else if (ctst_pkg::is_alpha(b)) begin
            mode_d = ctst_pkg::M_HWORD;
            if (dm_q < 3'd6 && ctst_pkg::dir_char(dm_q) == b) dm_d = dm_q + 3'd1;
            else dm_d = 3'd7;
          end else if (dm_q == 3'd6) begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_DEFINE, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; mode_d = ctst_pkg::M_IDLE; restart = 1'b1;
          end else begin
            err_d = 1'b1; ekind_d = ctst_pkg::ERR_DIRECTIVE; mode_d = ctst_pkg::M_IDLE;
            rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1;
          end
        end
        ctst_pkg::M_IDENT: begin
          if (ctst_pkg::is_alpha(b) || ctst_pkg::is_digit(b) || b == "_") begin
            do_ident = 1'b1;
          end else begin
            pk = ctst_pkg::K_IDENT;
            for (int i = 0; i < ctst_pkg::KwCount; i++)
              if (kc_q[i] && TLW'(ctst_pkg::kw_len(4'(i))) == tlen_q) pk = 6'(i + 1);
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, pk, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; restart = 1'b1;
          end
        end
        ctst_pkg::M_ZERO: begin
          if (b == "x" || b == "X") mode_d = ctst_pkg::M_HEX;
          else if (ctst_pkg::is_digit(b)) begin
            acc_d = 32'(hv); mode_d = ctst_pkg::M_DECNUM;
          end else begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_INT, acc_q, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; restart = 1'b1;
          end
        end
        ctst_pkg::M_DECNUM: begin
          if (ctst_pkg::is_digit(b)) acc_d = (acc_q << 3) + (acc_q << 1) + 32'(hv);
          else begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_INT, acc_q, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; restart = 1'b1;
          end
        end
        ctst_pkg::M_HEX: begin
          if (!hv[4]) acc_d = {acc_q[27:0], hv[3:0]};
          else begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_INT, acc_q, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; restart = 1'b1;
          end
        end
        ctst_pkg::M_COPEN: begin
          if (b == "\\") mode_d = ctst_pkg::M_CESC;
          else begin
            acc_d = 32'(b); mode_d = ctst_pkg::M_CCLOSE;
          end
        end
        ctst_pkg::M_CESC: begin
          acc_d = 32'(ctst_pkg::unescape(b)); mode_d = ctst_pkg::M_CCLOSE;
        end
        ctst_pkg::M_CCLOSE: begin
          if (b == "'") begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_CHAR, acc_q, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; mode_d = ctst_pkg::M_IDLE;
          end else begin
            err_d = 1'b1; ekind_d = ctst_pkg::ERR_CHAR; mode_d = ctst_pkg::M_IDLE;
            rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_q, tsc_q, 8'd0,
                          ctst_pkg::ERR_CHAR);
            n = n + 2'd1;
          end
        end
        ctst_pkg::M_STR, ctst_pkg::M_SESC: begin
          if (mode_q == ctst_pkg::M_STR && b == "\"") begin
            rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_STR, 32'(tlen_q), tsl_q, tsc_q,
                          8'd0, ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1; mode_d = ctst_pkg::M_IDLE;
          end else if (mode_q == ctst_pkg::M_STR && b == "\\") begin
            mode_d = ctst_pkg::M_SESC;
          end else begin
            sv = (mode_q == ctst_pkg::M_SESC) ? ctst_pkg::unescape(b) : b;
            rr[n[0]] = mk(ctst_pkg::RES_TEXT, ctst_pkg::K_STR, 32'd0, tsl_q, tsc_q, sv,
                          ctst_pkg::ERR_DIRECTIVE);
            n = n + 2'd1;
            tlen_d = tlen_q + TLW'(1);
            if (tlen_d >= TextCap) begin
              // String hits the text cap: close it on this beat.
              rr[n[0]] = mk(ctst_pkg::RES_TOKEN, ctst_pkg::K_STR, 32'(tlen_d), tsl_q, tsc_q,
                            8'd0, ctst_pkg::ERR_DIRECTIVE);
              n = n + 2'd1; mode_d = ctst_pkg::M_SCAP;
            end else begin
              mode_d = ctst_pkg::M_STR;
            end
          end
        end
        ctst_pkg::M_SCAP: begin
          mode_d = ctst_pkg::M_IDLE;
          restart = b != "\"";
        end
        default: restart = 1'b1;
      endcase

      if (restart && !err_d) begin
        tsl_d = ln_q; tsc_d = col_q; mode_d = ctst_pkg::M_IDLE;
        if (is_ws) begin
          mode_d = ctst_pkg::M_IDLE;
        end else if (ctst_pkg::is_alpha(b) || b == "_") begin
          mode_d = ctst_pkg::M_IDENT; tlen_d = '0; kc_d = '1; do_ident = 1'b1;
        end else if (ctst_pkg::is_digit(b)) begin
          acc_d = 32'(hv);
          mode_d = (b == "0") ? ctst_pkg::M_ZERO : ctst_pkg::M_DECNUM;
        end else begin
          case (b)
            "#": begin mode_d = ctst_pkg::M_HGAP; dm_d = 3'd0; end
            "'": mode_d = ctst_pkg::M_COPEN;
            "\"": begin mode_d = ctst_pkg::M_STR; tlen_d = '0; end
            "(", ")", "{", "}", "[", "]", ";", ",", ".", "*", "%": begin
              case (b)
                "(": pk = ctst_pkg::K_LPAREN;
                ")": pk = ctst_pkg::K_RPAREN;
                "{": pk = ctst_pkg::K_LBRACE;
                "}": pk = ctst_pkg::K_RBRACE;
                "[": pk = ctst_pkg::K_LBRACK;
                "]": pk = ctst_pkg::K_RBRACK;
                ";": pk = ctst_pkg::K_SEMI;
                ",": pk = ctst_pkg::K_COMMA;
                ".": pk = ctst_pkg::K_DOT;
                "*": pk = ctst_pkg::K_STAR;
                default: pk = ctst_pkg::K_PCT;
              endcase
              rr[n[0]] = mk(ctst_pkg::RES_TOKEN, pk, 32'd0, tsl_d, tsc_d, 8'd0,
                            ctst_pkg::ERR_DIRECTIVE);
              n = n + 2'd1;
            end
            "+", "-", "&", "|", "!", "=", "<", ">", "/": begin
              pend_d = b; mode_d = ctst_pkg::M_OP;
            end
            default: begin
              err_d = 1'b1; ekind_d = ctst_pkg::ERR_BYTE;
              rr[n[0]] = mk(ctst_pkg::RES_ERROR, ctst_pkg::K_END, 32'd0, tsl_d, tsc_d, 8'd0,
                            ctst_pkg::ERR_BYTE);
              n = n + 2'd1;
            end
          endcase
        end
      end

      // Identifier letter: prune keyword candidates, echo while under the cap.
      if (do_ident) begin
        for (int i = 0; i < ctst_pkg::KwCount; i++)
          if (kc_d[i] && (tlen_d >= TLW'(ctst_pkg::kw_len(4'(i))) ||
              ctst_pkg::kw_char(4'(i), tlen_d[2:0]) != b))
            kc_d[i] = 1'b0;
        if (tlen_d < TextCap) begin
          rr[n[0]] = mk(ctst_pkg::RES_TEXT, ctst_pkg::K_IDENT, 32'd0, tsl_d, tsc_d, b,
                        ctst_pkg::ERR_DIRECTIVE);
          n = n + 2'd1;
          tlen_d = tlen_d + TLW'(1);
        end
      end

      if (!err_d) begin
        if (b == "\n") begin
          if (ln_q < PosMax) ln_d = ln_q + PW'(1);
          col_d = PW'(1);
        end else if (col_q < PosMax) begin
          col_d = col_q + PW'(1);
        end
      end
    end

    if (n == 2'd2) rr[1].last = 1'b1;
    else rr[0].last = 1'b1;
    push_o.n  = take_i ? n : 2'd0;
    push_o.r0 = rr[0];
    push_o.r1 = rr[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ctst_pkg::M_IDLE; pend_q <= '0; acc_q <= '0; tlen_q <= '0; kc_q <= '1;
      dm_q <= '0; ln_q <= PW'(1); col_q <= PW'(1); tsl_q <= PW'(1); tsc_q <= PW'(1);
      err_q <= 1'b0; ekind_q <= ctst_pkg::ERR_DIRECTIVE;
    end else if (take_i) begin
      mode_q <= mode_d; pend_q <= pend_d; acc_q <= acc_d; tlen_q <= tlen_d; kc_q <= kc_d;
      dm_q <= dm_d; ln_q <= ln_d; col_q <= col_d; tsl_q <= tsl_d; tsc_q <= tsc_d;
      err_q <= err_d; ekind_q <= ekind_d;
    end
  end

endmodule

@@ src/ctst_resq.sv @@
// Back end of the tokenizer: result queue taking up to two entries a beat, giving one.
// Depends on ctst_pkg for the result and push types.
module ctst_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctst_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            pop_i,
  output ctst_pkg::res_t  head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);

  ctst_pkg::res_t     mem_q [Depth];
  logic [AW-1:0]      wp_q, rp_q;
  logic [AW:0]        cnt_q;
  logic               do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign room_o  = cnt_q <= (AW+1)'(Depth - 2);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wp_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wp_q + AW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + AW'(push_i.n);
      rp_q  <= rp_q + AW'(do_pop);
      cnt_q <= cnt_q + (AW+1)'(push_i.n) - (AW+1)'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("result queue overfilled");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + (AW+1)'($past(push_i.n)) - (AW+1)'($past(do_pop)))
    else $error("result queue count lost track");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> cnt_q <= (AW+1)'(Depth - 2))
    else $error("push into queue without room");

endmodule

@@ src/c_subset_tokenizer_core.sv @@
// Top level of the C-subset tokenizer: scanner front end plus result queue.
// Depends on ctst_pkg, ctst_scan and ctst_resq.
// Throughput: one source byte per cycle while the result queue has room for two
//   entries; the output side gives one result beat per cycle while m_axis_tready is high.
// Results are registered in the result queue, whose head drives the master side.
// Reset (rst_ni low, asynchronous): scanner idle at line 1 column 1, queue empty.
module c_subset_tokenizer_core #(
  parameter int unsigned MAX_TEXT       = ctst_pkg::MaxTextDef,
  parameter int unsigned POSITION_LIMIT = ctst_pkg::PosLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // kind, value, line, column, text_byte, error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] result_type
  output logic        m_axis_tlast    // last result of the input beat
);

  ctst_pkg::push_t push;
  ctst_pkg::res_t  head;
  logic            room, take;

  // Accept a byte only when the queue can hold both possible results.
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  ctst_scan #(
    .MaxText  (MAX_TEXT),
    .PosLimit (POSITION_LIMIT)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (s_axis_tdata),
    .end_i  (s_axis_tuser),
    .push_o (push)
  );

  ctst_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .head_o  (head)
  );

  // Pack the result beat, lowest field first, zero-fill to whole bytes.
  assign m_axis_tdata = {4'd0, head.err, head.tb, head.col, head.line, head.value, head.kind};
  assign m_axis_tuser = head.rtype;
  assign m_axis_tlast = head.last;

endmodule
